FILE: src/ppub_pkg.sv
// ---------------------------------------------------------------------------
// ppub_pkg
// shared types and constants for the parallel port message bridge
// ---------------------------------------------------------------------------
package ppub_pkg;

  // host IN packet size in bytes
  localparam int PACKET_SIZE = 64;
  localparam int FILL_W      = 10;
  // header bytes forwarded in one burst
  localparam int HDR_LEN     = 6;
  localparam int RIDX_W      = 3;

  // message phase, one step per port strobe
  typedef enum logic [3:0] {
    PH_CHAN      = 4'd0,
    PH_CMD       = 4'd1,
    PH_PARAM_A   = 4'd2,
    PH_PARAM_B   = 4'd3,
    PH_LEN_LO    = 4'd4,
    PH_LEN_HI    = 4'd5,
    PH_DATA_IN   = 4'd6,
    PH_TURN      = 4'd7,
    PH_RET_CODE  = 4'd8,
    PH_RLEN_LO   = 4'd9,
    PH_RLEN_HI   = 4'd10,
    PH_REPLY     = 4'd11,
    PH_FINISH    = 4'd12
  } phase_t;

  // host OUT bytes taken by a step
  localparam logic [1:0] TAKE_NONE   = 2'd0;
  localparam logic [1:0] TAKE_ONE    = 2'd1;
  localparam logic [1:0] TAKE_HEADER = 2'd3;

endpackage

FILE: src/parallel_port_to_usb_message_bridge_top.sv
// ---------------------------------------------------------------------------
// parallel_port_to_usb_message_bridge_top
// strobe-driven message bridge between a byte-wide parallel port and host
// IN/OUT byte streams
// ---------------------------------------------------------------------------
// One input transfer is one port strobe. The message state is updated in the
// cycle the strobe is accepted and its results land in a result register that
// drains one result transfer per cycle while the receiver is ready. A strobe
// giving one result frees the input as that result is transferred, so such
// strobes can follow back to back; the length-high strobe gives the six header
// bytes, the input side held while the result register drains them. The
// next strobe is taken in the same cycle the final result of the previous one
// is transferred.
module parallel_port_to_usb_message_bridge_top (
  input  logic       clk,
  input  logic       rst_n,
  // strobe channel
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_bus_byte,
  input  logic       in_reset_seen,
  input  logic [7:0] in_host_next0,
  input  logic [7:0] in_host_next1,
  input  logic [7:0] in_host_next2,
  // result channel
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_in_push,
  output logic [7:0] out_in_byte,
  output logic       out_in_flush,
  output logic [7:0] out_port_byte,
  output logic       out_port_drive,
  output logic [1:0] out_host_taken,
  output logic       out_host_release,
  output logic       out_last
);
  import ppub_pkg::*;

  // message state
  phase_t              phase_r, phase_nxt;
  logic [7:0]          chan_r, chan_nxt;
  logic [7:0]          cmd_r, cmd_nxt;
  logic [7:0]          param_a_r, param_a_nxt;
  logic [7:0]          param_b_r, param_b_nxt;
  logic [15:0]         count_r, count_nxt;
  logic [FILL_W-1:0]   fill_r, fill_nxt;
  logic [7:0]          port_r, port_nxt;
  logic                drive_r, drive_nxt;

  // result register
  logic                res_valid_r;
  logic [RIDX_W-1:0]   res_n_r, res_idx_r;
  logic [7:0]          res_byte_r [HDR_LEN];
  logic [HDR_LEN-1:0]  res_flush_r;
  logic                res_push_r;
  logic [7:0]          res_port_r;
  logic                res_drive_r;
  logic [1:0]          res_taken_r;
  logic                res_release_r;

  // step outputs
  logic [RIDX_W-1:0]   st_n;
  logic [7:0]          st_byte [HDR_LEN];
  logic [HDR_LEN-1:0]  st_flush;
  logic                st_push;
  logic [1:0]          st_taken;
  logic                st_release;

  logic                in_xfer, out_xfer, res_last;
  logic [15:0]         count_dec;
  logic [FILL_W-1:0]   fill_inc;

  assign res_last = (res_idx_r == res_n_r - RIDX_W'(1));
  assign out_xfer = res_valid_r && out_ready;
  assign in_ready = !res_valid_r || (out_ready && res_last);
  assign in_xfer  = in_valid && in_ready;

  assign count_dec = count_r - 16'd1;
  assign fill_inc  = fill_r + FILL_W'(1);

  // one strobe of the message state machine
  always_comb begin
    phase_nxt   = phase_r;
    chan_nxt    = chan_r;
    cmd_nxt     = cmd_r;
    param_a_nxt = param_a_r;
    param_b_nxt = param_b_r;
    count_nxt   = count_r;
    fill_nxt    = fill_r;
    port_nxt    = port_r;
    drive_nxt   = drive_r;
    st_n        = RIDX_W'(1);
    st_push     = 1'b0;
    st_taken    = TAKE_NONE;
    st_release  = 1'b0;
    st_flush    = '0;
    for (int i = 0; i < HDR_LEN; i++) begin
      st_byte[i] = 8'd0;
    end
    unique case (phase_r)
      PH_CHAN: begin
        chan_nxt  = in_bus_byte;
        phase_nxt = PH_CMD;
      end
      PH_CMD: begin
        cmd_nxt   = in_bus_byte;
        phase_nxt = PH_PARAM_A;
      end
      PH_PARAM_A: begin
        param_a_nxt = in_bus_byte;
        phase_nxt   = PH_PARAM_B;
      end
      PH_PARAM_B: begin
        param_b_nxt = in_bus_byte;
        phase_nxt   = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        count_nxt = {count_r[15:8], in_bus_byte};
        phase_nxt = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        // header burst; fill never reaches the packet size twice in six bytes
        count_nxt  = {in_bus_byte, count_r[7:0]};
        phase_nxt  = (count_nxt != 16'd0) ? PH_DATA_IN : PH_TURN;
        st_n       = RIDX_W'(HDR_LEN);
        st_push    = 1'b1;
        st_byte[0] = chan_r;
        st_byte[1] = cmd_r;
        st_byte[2] = param_a_r;
        st_byte[3] = param_b_r;
        st_byte[4] = count_r[7:0];
        st_byte[5] = in_bus_byte;
        for (int i = 0; i < HDR_LEN - 1; i++) begin
          st_flush[i] = (fill_r + FILL_W'(i + 1)) == FILL_W'(PACKET_SIZE);
        end
        st_flush[HDR_LEN-1] = 1'b1;
        fill_nxt = '0;
      end
      PH_DATA_IN: begin
        count_nxt  = count_dec;
        st_push    = 1'b1;
        st_byte[0] = in_bus_byte;
        if (count_dec == 16'd0 || fill_inc >= FILL_W'(PACKET_SIZE)) begin
          st_flush[0] = 1'b1;
          fill_nxt    = '0;
        end else begin
          fill_nxt = fill_inc;
        end
        if (count_dec == 16'd0) begin
          phase_nxt = PH_TURN;
        end
      end
      PH_TURN: begin
        phase_nxt = PH_RET_CODE;
        drive_nxt = 1'b1;
      end
      PH_RET_CODE: begin
        port_nxt  = in_host_next0;
        count_nxt = {in_host_next2, in_host_next1};
        st_taken  = TAKE_HEADER;
        phase_nxt = PH_RLEN_LO;
      end
      PH_RLEN_LO: begin
        port_nxt  = count_r[7:0];
        phase_nxt = PH_RLEN_HI;
      end
      PH_RLEN_HI: begin
        port_nxt  = count_r[15:8];
        phase_nxt = (count_r != 16'd0) ? PH_REPLY : PH_FINISH;
      end
      PH_REPLY: begin
        port_nxt  = in_host_next0;
        st_taken  = TAKE_ONE;
        count_nxt = count_dec;
        if (count_dec == 16'd0) begin
          phase_nxt = PH_FINISH;
        end
      end
      PH_FINISH: begin
        st_release = 1'b1;
        drive_nxt  = 1'b0;
        phase_nxt  = PH_CHAN;
      end
      default: begin
        drive_nxt = 1'b0;
        phase_nxt = PH_CHAN;
      end
    endcase
    // bus reset seen during acknowledge
    if (in_reset_seen) begin
      phase_nxt = PH_CHAN;
      drive_nxt = 1'b0;
    end
  end

  // message state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_CHAN;
      chan_r    <= '0;
      cmd_r     <= '0;
      param_a_r <= '0;
      param_b_r <= '0;
      count_r   <= '0;
      fill_r    <= '0;
      port_r    <= '0;
      drive_r   <= 1'b0;
    end else if (in_xfer) begin
      phase_r   <= phase_nxt;
      chan_r    <= chan_nxt;
      cmd_r     <= cmd_nxt;
      param_a_r <= param_a_nxt;
      param_b_r <= param_b_nxt;
      count_r   <= count_nxt;
      fill_r    <= fill_nxt;
      port_r    <= port_nxt;
      drive_r   <= drive_nxt;
    end
  end

  // result register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
      res_n_r     <= '0;
      res_idx_r   <= '0;
    end else if (in_xfer) begin
      res_valid_r <= 1'b1;
      res_n_r     <= st_n;
      res_idx_r   <= '0;
    end else if (out_xfer) begin
      if (res_last) begin
        res_valid_r <= 1'b0;
      end else begin
        res_idx_r <= res_idx_r + RIDX_W'(1);
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      for (int i = 0; i < HDR_LEN; i++) begin
        res_byte_r[i] <= st_byte[i];
      end
      res_flush_r   <= st_flush;
      res_push_r    <= st_push;
      res_port_r    <= port_nxt;
      res_drive_r   <= drive_nxt;
      res_taken_r   <= st_taken;
      res_release_r <= st_release;
    end
  end

  // result transfer fields
  assign out_valid        = res_valid_r;
  assign out_in_push      = res_push_r;
  assign out_in_byte      = res_byte_r[res_idx_r];
  assign out_in_flush     = res_flush_r[res_idx_r];
  assign out_port_byte    = res_port_r;
  assign out_port_drive   = res_drive_r;
  assign out_host_taken   = res_last ? res_taken_r : TAKE_NONE;
  assign out_host_release = res_last ? res_release_r : 1'b0;
  assign out_last         = res_last;

  // a new strobe only enters when the previous results are done
  a_accept_free: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && res_valid_r) |-> (out_ready && res_last))
    else $error("strobe accepted over pending results");

  // releasing the OUT packet always hands the port back
  a_release_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_host_release) |-> !out_port_drive)
    else $error("port still driven at release");

  // a flush only ends a pushed byte
  a_flush_push: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_in_flush) |-> out_in_push)
    else $error("flush without push");

  // packet fill stays below the packet size
  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r < FILL_W'(PACKET_SIZE))
    else $error("packet fill out of range");

  // result index never runs past the burst length
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid_r |-> (res_idx_r < res_n_r))
    else $error("result index past burst");

endmodule

FILE: verif/parallel_port_to_usb_message_bridge_top_tb.sv
// ---------------------------------------------------------------------------
// parallel_port_to_usb_message_bridge_top_tb
// Self-checking bench for the parallel port message bridge. Port strobes are
// sent through the input handshake while a behavioral copy of the message
// state machine predicts every result transfer. Directed messages cover the
// field extremes, the header burst and bus resets. Random traffic follows the
// message protocol with random content, occasional bus resets, long messages
// that fill host packets, random idling on both sides and one long receiver
// hold-off that backs the block up into its input.
// ---------------------------------------------------------------------------
module parallel_port_to_usb_message_bridge_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ppub_pkg::*;

  localparam int RESET_CYCLES   = 11;
  localparam int RANDOM_STROBES = 304;
  localparam int HOLD_OFF       = 300;
  localparam int DRAIN_CYCLES   = 16;
  localparam int CYCLE_LIMIT    = 150000;

  // one port strobe
  typedef struct packed {
    logic [7:0] bus;
    logic       bus_reset;
    logic [7:0] next0;
    logic [7:0] next1;
    logic [7:0] next2;
  } strobe_t;

  // one result transfer
  typedef struct packed {
    logic       push_bit;
    logic [7:0] in_data;
    logic       flush_bit;
    logic [7:0] port_data;
    logic       drive_bit;
    logic [1:0] taken;
    logic       rel_bit;
    logic       last_bit;
  } port_result_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_bus_byte = 8'h00;
  logic       in_reset_seen = 1'b0;
  logic [7:0] in_host_next0 = 8'h00;
  logic [7:0] in_host_next1 = 8'h00;
  logic [7:0] in_host_next2 = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       out_in_push;
  logic [7:0] out_in_byte;
  logic       out_in_flush;
  logic [7:0] out_port_byte;
  logic       out_port_drive;
  logic [1:0] out_host_taken;
  logic       out_host_release;
  logic       out_last;

  // predicted message state
  phase_t            msg_phase = PH_CHAN;
  logic [7:0]        m_chan = '0;
  logic [7:0]        m_cmd = '0;
  logic [7:0]        m_param_a = '0;
  logic [7:0]        m_param_b = '0;
  logic [15:0]       m_count = '0;
  logic [FILL_W-1:0] m_fill = '0;
  logic [7:0]        m_port = '0;
  logic              m_drive = 1'b0;

  port_result_t pending_results[$];

  bit send_idle = 1'b1;
  bit sink_idle = 1'b1;
  bit long_len = 1'b0;
  int hold_cycles = 0;
  int cycle_count = 0;
  int error_count = 0;
  int strobes_sent = 0;
  int results_seen = 0;
  int flush_count = 0;
  int bus_resets = 0;
  int messages_done = 0;

  parallel_port_to_usb_message_bridge_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_bus_byte      (in_bus_byte),
    .in_reset_seen    (in_reset_seen),
    .in_host_next0    (in_host_next0),
    .in_host_next1    (in_host_next1),
    .in_host_next2    (in_host_next2),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_in_push      (out_in_push),
    .out_in_byte      (out_in_byte),
    .out_in_flush     (out_in_flush),
    .out_port_byte    (out_port_byte),
    .out_port_drive   (out_port_drive),
    .out_host_taken   (out_host_taken),
    .out_host_release (out_host_release),
    .out_last         (out_last)
  );

  // 4 ns clock
  always #2 clk = ~clk;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // host packet fill, returns 1 when the packet closes
  function automatic bit add_to_packet(input bit force_flush);
    m_fill = m_fill + FILL_W'(1);
    if (force_flush || m_fill >= FILL_W'(PACKET_SIZE)) begin
      m_fill = '0;
      flush_count++;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // advance the message state by one strobe and queue its results
  task automatic step_bridge(input strobe_t s);
    port_result_t       r;
    logic [7:0]         hdr [HDR_LEN];
    logic [HDR_LEN-1:0] hdr_flush;
    bit                 header;
    r = '0;
    header = 1'b0;
    r.taken = TAKE_NONE;
    case (msg_phase)
      PH_CHAN: begin
        m_chan = s.bus;
        msg_phase = PH_CMD;
      end
      PH_CMD: begin
        m_cmd = s.bus;
        msg_phase = PH_PARAM_A;
      end
      PH_PARAM_A: begin
        m_param_a = s.bus;
        msg_phase = PH_PARAM_B;
      end
      PH_PARAM_B: begin
        m_param_b = s.bus;
        msg_phase = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        m_count[7:0] = s.bus;
        msg_phase = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        m_count[15:8] = s.bus;
        msg_phase = (m_count != 16'd0) ? PH_DATA_IN : PH_TURN;
        hdr = '{m_chan, m_cmd, m_param_a, m_param_b, m_count[7:0], m_count[15:8]};
        for (int i = 0; i < HDR_LEN; i++) hdr_flush[i] = add_to_packet(i == HDR_LEN - 1);
        header = 1'b1;
      end
      PH_DATA_IN: begin
        m_count = m_count - 16'd1;
        r.push_bit = 1'b1;
        r.in_data = s.bus;
        r.flush_bit = add_to_packet(m_count == 16'd0);
        if (m_count == 16'd0) msg_phase = PH_TURN;
      end
      PH_TURN: begin
        msg_phase = PH_RET_CODE;
        m_drive = 1'b1;
      end
      PH_RET_CODE: begin
        m_port = s.next0;
        m_count = {s.next2, s.next1};
        r.taken = TAKE_HEADER;
        msg_phase = PH_RLEN_LO;
      end
      PH_RLEN_LO: begin
        m_port = m_count[7:0];
        msg_phase = PH_RLEN_HI;
      end
      PH_RLEN_HI: begin
        m_port = m_count[15:8];
        msg_phase = (m_count != 16'd0) ? PH_REPLY : PH_FINISH;
      end
      PH_REPLY: begin
        m_port = s.next0;
        r.taken = TAKE_ONE;
        m_count = m_count - 16'd1;
        if (m_count == 16'd0) msg_phase = PH_FINISH;
      end
      PH_FINISH: begin
        r.rel_bit = 1'b1;
        m_drive = 1'b0;
        msg_phase = PH_CHAN;
        messages_done++;
      end
      default: begin
        m_drive = 1'b0;
        msg_phase = PH_CHAN;
      end
    endcase
    // bus reset drops back to the channel phase with the port as input
    if (s.bus_reset) begin
      msg_phase = PH_CHAN;
      m_drive = 1'b0;
      bus_resets++;
    end
    r.port_data = m_port;
    r.drive_bit = m_drive;
    if (header) begin
      for (int i = 0; i < HDR_LEN; i++) begin
        r.push_bit = 1'b1;
        r.in_data = hdr[i];
        r.flush_bit = hdr_flush[i];
        r.last_bit = (i == HDR_LEN - 1);
        pending_results.push_back(r);
      end
    end else begin
      r.last_bit = 1'b1;
      pending_results.push_back(r);
    end
  endtask

  // offer one strobe and wait for its transfer
  task automatic send_strobe(input strobe_t s);
    int gap;
    gap = send_idle ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    step_bridge(s);
    in_valid      <= 1'b1;
    in_bus_byte   <= s.bus;
    in_reset_seen <= s.bus_reset;
    in_host_next0 <= s.next0;
    in_host_next1 <= s.next1;
    in_host_next2 <= s.next2;
    do @(posedge clk); while (!in_ready);
    strobes_sent++;
  endtask

  function automatic strobe_t make_strobe(input logic [7:0] bus, input logic bus_reset,
                                          input logic [7:0] next0, input logic [7:0] next1,
                                          input logic [7:0] next2);
    strobe_t s;
    s = '{bus, bus_reset, next0, next1, next2};
    return s;
  endfunction

  // protocol-aware random strobe, shaped by the predicted phase
  function automatic strobe_t random_strobe();
    strobe_t s;
    int      pick;
    s.bus = 8'($urandom);
    s.next0 = 8'($urandom);
    s.next1 = 8'($urandom);
    s.next2 = 8'($urandom);
    s.bus_reset = ($urandom_range(0, 99) < 2);
    pick = $urandom_range(0, 99);
    case (msg_phase)
      PH_LEN_LO: begin
        long_len = (pick >= 88);
        if (pick < 12) s.bus = 8'h00;
        else if (pick < 70) s.bus = 8'($urandom_range(1, 8));
        else if (pick < 88) s.bus = 8'($urandom_range(56, 72));
      end
      PH_LEN_HI: s.bus = long_len ? 8'($urandom_range(1, 255)) : 8'h00;
      // long transfers are sometimes cut short by a bus reset
      PH_DATA_IN: if (m_count > 16'd100 && pick < 10) s.bus_reset = 1'b1;
      PH_RET_CODE: begin
        if (pick < 15) {s.next2, s.next1} = 16'h0000;
        else if (pick < 80) {s.next2, s.next1} = 16'($urandom_range(1, 6));
        else s.next2 = 8'($urandom_range(1, 255));
      end
      PH_REPLY: if (m_count > 16'd20 && pick < 10) s.bus_reset = 1'b1;
      default: ;
    endcase
    return s;
  endfunction

  // full message with one data byte and one reply byte, field extremes
  task automatic test_directed_message();
    send_strobe(make_strobe(8'h00, 1'b0, 8'hFF, 8'hFF, 8'hFF));
    send_strobe(make_strobe(8'hFF, 1'b0, 8'h00, 8'h00, 8'h00));
    send_strobe(make_strobe(8'h00, 1'b0, 8'hFF, 8'hFF, 8'hFF));
    send_strobe(make_strobe(8'hFF, 1'b0, 8'h00, 8'h00, 8'h00));
    send_strobe(make_strobe(8'h01, 1'b0, 8'h00, 8'h00, 8'h00));
    send_strobe(make_strobe(8'h00, 1'b0, 8'h00, 8'h00, 8'h00));
    send_strobe(make_strobe(8'hFF, 1'b0, 8'h00, 8'h00, 8'h00));
    send_strobe(make_strobe(8'hA5, 1'b0, 8'h00, 8'h00, 8'h00));
    send_strobe(make_strobe(8'h00, 1'b0, 8'hFF, 8'h01, 8'h00));
    send_strobe(make_strobe(8'h00, 1'b0, 8'h00, 8'h00, 8'h00));
    send_strobe(make_strobe(8'h00, 1'b0, 8'h00, 8'h00, 8'h00));
    send_strobe(make_strobe(8'h5A, 1'b0, 8'h00, 8'hFF, 8'hFF));
    send_strobe(make_strobe(8'h00, 1'b0, 8'h00, 8'h00, 8'h00));
  endtask

  // zero-length message reset at turn-around, then a reset on the header burst
  task automatic test_bus_reset();
    send_strobe(make_strobe(8'hFF, 1'b0, 8'h00, 8'h00, 8'h00));
    send_strobe(make_strobe(8'h00, 1'b0, 8'h00, 8'h00, 8'h00));
    send_strobe(make_strobe(8'hFF, 1'b0, 8'h00, 8'h00, 8'h00));
    send_strobe(make_strobe(8'h00, 1'b0, 8'h00, 8'h00, 8'h00));
    send_strobe(make_strobe(8'h00, 1'b0, 8'h00, 8'h00, 8'h00));
    send_strobe(make_strobe(8'h00, 1'b0, 8'h00, 8'h00, 8'h00));
    send_strobe(make_strobe(8'h00, 1'b1, 8'h00, 8'h00, 8'h00));
    send_strobe(make_strobe(8'h12, 1'b0, 8'h00, 8'h00, 8'h00));
    send_strobe(make_strobe(8'h34, 1'b0, 8'h00, 8'h00, 8'h00));
    send_strobe(make_strobe(8'h56, 1'b0, 8'h00, 8'h00, 8'h00));
    send_strobe(make_strobe(8'h78, 1'b0, 8'h00, 8'h00, 8'h00));
    send_strobe(make_strobe(8'h00, 1'b0, 8'h00, 8'h00, 8'h00));
    send_strobe(make_strobe(8'hFF, 1'b1, 8'h00, 8'h00, 8'h00));
  endtask

  // receiver holds off while strobes keep coming back to back
  task automatic test_result_backpressure();
    send_idle = 1'b0;
    hold_cycles = HOLD_OFF;
    for (int n = 0; n < 30; n++) send_strobe(random_strobe());
    send_idle = 1'b1;
  endtask

  // random messages with stretches of idling and of full rate
  task automatic test_random_traffic();
    for (int n = 0; n < RANDOM_STROBES; n++) begin
      if (n % 40 == 0) begin
        send_idle = ($urandom_range(0, 3) != 0);
        sink_idle = ($urandom_range(0, 3) != 0);
      end
      send_strobe(random_strobe());
    end
  endtask

  // result side ready with random waits per transfer
  initial begin : result_sink
    int wait_cyc;
    @(posedge clk iff rst_n);
    forever begin
      wait_cyc = sink_idle ? $urandom_range(0, 6) : 0;
      if (hold_cycles > 0) begin
        wait_cyc += hold_cycles;
        hold_cycles = 0;
      end
      if (wait_cyc > 0) begin
        out_ready <= 1'b0;
        repeat (wait_cyc) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      error_count++;
    end
  endfunction

  // compare every result transfer with the oldest prediction
  always @(posedge clk) begin : result_check
    port_result_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result transfer with no prediction pending");
        error_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("in_push", 16'(want.push_bit), 16'(out_in_push));
        check_field("in_byte", 16'(want.in_data), 16'(out_in_byte));
        check_field("in_flush", 16'(want.flush_bit), 16'(out_in_flush));
        check_field("port_byte", 16'(want.port_data), 16'(out_port_byte));
        check_field("port_drive", 16'(want.drive_bit), 16'(out_port_drive));
        check_field("host_taken", 16'(want.taken), 16'(out_host_taken));
        check_field("host_release", 16'(want.rel_bit), 16'(out_host_release));
        check_field("last", 16'(want.last_bit), 16'(out_last));
      end
    end
  end

  // run limit
  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : run_tests
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_message();
    test_bus_reset();
    test_result_backpressure();
    test_random_traffic();
    in_valid <= 1'b0;
    // drain outstanding results
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d predicted results never arrived", pending_results.size());
      error_count++;
    end
    $display("covered %0d strobes, %0d result transfers, %0d complete messages",
             strobes_sent, results_seen, messages_done);
    $display("host packets closed %0d times, bus resets %0d", flush_count, bus_resets);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
